// ----- rtl/bounded_ordered_list_engine_assert.svh -----
// Assertion macros used by the list engine controller.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bole_pkg.sv -----
package bole_pkg;

  // Sizes of the list and of the request and result fields.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 3;
  localparam int LEN_W    = 5;

  // Operation codes of a request.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  // Status codes of a result.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  // What one cell loads at the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } cell_sel_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  // Per-cell selects and the broadcast insert value.
  typedef struct packed {
    cell_sel_t [CAPACITY-1:0] sel;
    logic [DATA_W-1:0]        value;
  } chain_ctl_t;

endpackage

// ----- rtl/bole_cell.sv -----
module bole_cell
  import bole_pkg::*;
(
  input  logic              clk,
  input  cell_sel_t         sel,
  input  logic [DATA_W-1:0] ins_value,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  input  logic [DATA_W-1:0] head_value,
  output logic [DATA_W-1:0] value_o
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  // Pick the new entry: keep it, take the insert value, a neighbor's, or the head cell's.
  always_comb begin
    case (sel)
      CELL_HOLD:  value_nxt = value_r;
      CELL_LOAD:  value_nxt = ins_value;
      CELL_LEFT:  value_nxt = left_value;
      CELL_RIGHT: value_nxt = right_value;
      CELL_HEAD:  value_nxt = head_value;
      default:    value_nxt = value_r;
    endcase
  end

  // Entry storage; contents are only read after being written.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

// ----- rtl/bole_ctrl.sv -----
module bole_ctrl
  import bole_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OP_W-1:0]   op,
  input  logic [DATA_W-1:0] ins_value,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] head_value,
  output logic              busy,
  output chain_ctl_t        chain_ctl,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_entry_value,
  output logic              out_final_item,
  output logic [LEN_W-1:0]  out_length
);

`include "bounded_ordered_list_engine_assert.svh"

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  disp_cnt_r, disp_cnt_nxt;
  logic              valid_r, valid_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              final_r, final_nxt;

  op_t               op_dec;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    cnt_ext;
  logic              list_full;
  logic              list_empty;
  logic              do_ins;
  logic              do_del;
  logic [CNT_W-1:0]  idx;
  status_t           upd_status;
  logic              disp_last;

  assign op_dec     = op_t'(op);
  assign pos_ext    = {1'b0, position};
  assign cnt_ext    = (POS_W + 1)'(count_r);
  assign list_full  = (count_r >= CNT_W'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign disp_last  = (disp_cnt_r == count_r - CNT_W'(1));
  assign busy       = (state_r == S_DISP);

  // Decode an update request into its status and the place it touches.
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    idx        = '0;
    upd_status = ST_OK;
    case (op_dec)
      OP_INS_FRONT: begin
        if (list_full) upd_status = ST_FULL;
        else           do_ins     = 1'b1;
      end
      OP_INS_END: begin
        idx = count_r;
        if (list_full) upd_status = ST_FULL;
        else           do_ins     = 1'b1;
      end
      OP_INS_POS: begin
        if (pos_ext == (POS_W + 1)'(1)) begin
          if (list_full) upd_status = ST_FULL;
          else           do_ins     = 1'b1;
        end else if (pos_ext == '0) begin
          upd_status = ST_BADPOS;
        end else if (list_empty) begin
          upd_status = ST_RANGE;
        end else if (list_full) begin
          upd_status = ST_FULL;
        end else if (pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
          upd_status = ST_RANGE;
        end else begin
          idx    = CNT_W'(pos_ext - (POS_W + 1)'(1));
          do_ins = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (list_empty) upd_status = ST_EMPTY;
        else            do_del     = 1'b1;
      end
      OP_DEL_END: begin
        idx = count_r - CNT_W'(1);
        if (list_empty) upd_status = ST_EMPTY;
        else            do_del     = 1'b1;
      end
      OP_DEL_POS: begin
        if (list_empty) begin
          upd_status = ST_EMPTY;
        end else if (pos_ext == '0) begin
          upd_status = ST_BADPOS;
        end else if (pos_ext > cnt_ext) begin
          upd_status = ST_RANGE;
        end else begin
          idx    = CNT_W'(pos_ext - (POS_W + 1)'(1));
          do_del = 1'b1;
        end
      end
      default: begin
        upd_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && op_dec == OP_DISPLAY && !list_empty) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (disp_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell selects, count update and the next result.
  always_comb begin
    chain_ctl.value = ins_value;
    for (int i = 0; i < CAPACITY; i++) begin
      chain_ctl.sel[i] = CELL_HOLD;
    end
    count_nxt    = count_r;
    disp_cnt_nxt = disp_cnt_r;
    valid_nxt    = 1'b0;
    status_nxt   = ST_OK;
    entry_nxt    = '0;
    final_nxt    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          valid_nxt = 1'b1;
          if (op_dec == OP_DISPLAY) begin
            if (list_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              valid_nxt    = 1'b0;
              disp_cnt_nxt = '0;
            end
          end else begin
            status_nxt = upd_status;
            // Insert: cells past the slot shift right, the slot loads the value.
            if (do_ins) begin
              count_nxt = count_r + CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (CNT_W'(i) == idx)     chain_ctl.sel[i] = CELL_LOAD;
                else if (CNT_W'(i) > idx) chain_ctl.sel[i] = CELL_LEFT;
              end
            end
            // Delete: cells from the slot on take their right neighbor.
            if (do_del) begin
              count_nxt = count_r - CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (CNT_W'(i) >= idx) chain_ctl.sel[i] = CELL_RIGHT;
              end
            end
          end
        end
      end
      S_DISP: begin
        // Stream the head and rotate the occupied cells by one.
        valid_nxt    = 1'b1;
        entry_nxt    = head_value;
        final_nxt    = disp_last;
        disp_cnt_nxt = disp_cnt_r + CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == count_r - CNT_W'(1))    chain_ctl.sel[i] = CELL_HEAD;
          else if (CNT_W'(i) < count_r - CNT_W'(1)) chain_ctl.sel[i] = CELL_RIGHT;
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      disp_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      disp_cnt_r <= disp_cnt_nxt;
      valid_r    <= valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    final_r  <= final_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_value = entry_r;
  assign out_final_item  = final_r;
  assign out_length      = LEN_W'(count_r);

  // The count never passes the capacity.
  `BOLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY),
    "entry count above capacity")
  // A display walk never changes the count.
  `BOLE_ASSERT_NEXT(a_disp_count, clk, rst_n, state_r == S_DISP,
    count_r == $past(count_r), "count changed during display")
  // The display index stays inside the occupied cells.
  `BOLE_ASSERT_NOW(a_disp_idx, clk, rst_n, state_r == S_DISP,
    disp_cnt_r < count_r, "display index beyond count")
  // Any accepted update request answers in the next cycle.
  `BOLE_ASSERT_NEXT(a_upd_answer, clk, rst_n,
    start && state_r == S_IDLE && op_dec != OP_DISPLAY,
    valid_r && final_r, "update request without a single result")

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// Channel   Ports                                              Flow
// request   start, busy, in_operation, in_value, in_position   taken when start && !busy
// result    out_valid, out_status, out_entry_value,            one-cycle strobe
//           out_final_item, out_length
//
// An insert or delete moves the whole row of cells together; its status is
// registered and appears in the cycle after the request is taken, and a new
// request may follow at once. A display keeps busy high while the occupied
// cells rotate past the head cell, giving one entry per cycle.
// Reset is synchronous and empties the list; cell contents are not cleared.
// The result side cannot stall, so no result ever waits.
module bounded_ordered_list_engine
  import bole_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_entry_value,
  output logic              out_final_item,
  output logic [LEN_W-1:0]  out_length
);

  chain_ctl_t        chain_ctl;
  logic [DATA_W-1:0] cell_value [CAPACITY];

  // Sequencer: decodes requests, steers the cells and forms results.
  bole_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .op              (in_operation),
    .ins_value       (in_value),
    .position        (in_position),
    .head_value      (cell_value[0]),
    .busy            (busy),
    .chain_ctl       (chain_ctl),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_final_item  (out_final_item),
    .out_length      (out_length)
  );

  // Row of cells; the ends see their own value as the missing neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bole_cell u_cell (
      .clk         (clk),
      .sel         (chain_ctl.sel[g]),
      .ins_value   (chain_ctl.value),
      .left_value  (cell_value[(g == 0) ? 0 : g - 1]),
      .right_value (cell_value[(g == CAPACITY - 1) ? g : g + 1]),
      .head_value  (cell_value[0]),
      .value_o     (cell_value[g])
    );
  end

endmodule
